@@ rtl/vpl_pkg.sv @@
// ----------------------------------------------------------------------------
// vpl_pkg
// Types and constants shared by the vertex projection and segment blocks.
// ----------------------------------------------------------------------------
package vpl_pkg;

    localparam int CLIP_W = 36;   // clip-space x, y, w in Q.20
    localparam int NUM_W  = 54;   // screen numerator
    localparam int DEN_W  = 38;   // divisor magnitude, 2|w| or 2^21
    localparam int QBITS  = 15;   // quotient bits below the saturation limit

    localparam logic signed [CLIP_W-1:0] ONE_Q20   = 36'sd1048576;
    localparam logic [DEN_W-1:0]         DEN_W_ZERO = 38'd2097152;

    localparam logic [2:0] CFG_ROW_ONE   = 3'd0;
    localparam logic [2:0] CFG_ROW_TWO   = 3'd1;
    localparam logic [2:0] CFG_ROW_THREE = 3'd2;
    localparam logic [2:0] CFG_ROW_FOUR  = 3'd3;
    localparam logic [2:0] CFG_VP_LEFT   = 3'd4;
    localparam logic [2:0] CFG_VP_TOP    = 3'd5;
    localparam logic [2:0] CFG_VP_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_VP_HEIGHT = 3'd7;

    localparam logic [63:0] RST_ROW_ONE   = 64'd4096;
    localparam logic [63:0] RST_ROW_TWO   = 64'd268435456;
    localparam logic [63:0] RST_ROW_THREE = 64'd17592186044416;
    localparam logic [63:0] RST_ROW_FOUR  = 64'd1152921504606846976;
    localparam logic [12:0] RST_VP_WIDTH  = 13'd640;
    localparam logic [12:0] RST_VP_HEIGHT = 13'd480;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic               last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               closing_segment;
    } t_segment;

    typedef struct packed {
        logic [3:0][63:0] matrix;
        logic [11:0]      left;
        logic [11:0]      top;
        logic [12:0]      width;
        logic [12:0]      height;
    } t_cfg;

    typedef struct packed {
        logic signed [NUM_W-1:0] num_x;
        logic signed [NUM_W-1:0] num_y;
        logic [DEN_W-1:0]        den;
        logic                    last;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef enum logic [2:0] {
        FE_IDLE, FE_MAT_X, FE_MAT_Y, FE_MAT_W, FE_NUM_X, FE_NUM_Y, FE_PUSH
    } t_fe_state;

    typedef enum logic [2:0] {
        BE_IDLE, BE_LOAD, BE_DIV, BE_PAIR, BE_EMIT_A, BE_EMIT_B
    } t_be_state;

endpackage

@@ rtl/vertex_project_to_line_segments.sv @@
// ----------------------------------------------------------------------------
// vertex_project_to_line_segments
// Vertex transform, divide by w and viewport map, emitting polygon edges.
// ----------------------------------------------------------------------------
// One vertex word at a time passes the transform front (one matrix column
// or one numerator per cycle) and then the back, which pops it, loads
// the two bit-serial dividers that produce 15 quotient bits each, one a cycle,
// then pairs the point and sends zero, one or two segment words out. The two
// halves run concurrently through a two-entry queue; the front can take a new
// vertex while the back divides. Matrix and viewport writes are taken at
// any time via the config port but must only be made while the block is idle.
module vertex_project_to_line_segments import vpl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_vertex     i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_segment    o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg         r_cfg;
    logic         w_push, w_pop;
    t_work        w_push_work, w_head;
    t_fifo_status w_fifo_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.matrix[0] <= RST_ROW_ONE;
            r_cfg.matrix[1] <= RST_ROW_TWO;
            r_cfg.matrix[2] <= RST_ROW_THREE;
            r_cfg.matrix[3] <= RST_ROW_FOUR;
            r_cfg.left      <= '0;
            r_cfg.top       <= '0;
            r_cfg.width     <= RST_VP_WIDTH;
            r_cfg.height    <= RST_VP_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROW_ONE:   r_cfg.matrix[0] <= i_cfg_data;
                CFG_ROW_TWO:   r_cfg.matrix[1] <= i_cfg_data;
                CFG_ROW_THREE: r_cfg.matrix[2] <= i_cfg_data;
                CFG_ROW_FOUR:  r_cfg.matrix[3] <= i_cfg_data;
                CFG_VP_LEFT:   r_cfg.left      <= i_cfg_data[11:0];
                CFG_VP_TOP:    r_cfg.top       <= i_cfg_data[11:0];
                CFG_VP_WIDTH:  r_cfg.width     <= i_cfg_data[12:0];
                CFG_VP_HEIGHT: r_cfg.height    <= i_cfg_data[12:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    vpl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_full     (w_fifo_status.full),
        .o_push     (w_push),
        .o_work     (w_push_work)
    );

    vpl_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_work),
        .i_pop    (w_pop),
        .o_data   (w_head),
        .o_status (w_fifo_status)
    );

    vpl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_fifo_status.empty),
        .i_work      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // queue never written when full nor read when empty
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_status.full)
        else $error("work queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_status.empty)
        else $error("work queue underflow");

    // a taken vertex keeps the front busy on the next cycle
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("front took a vertex while busy");

endmodule

@@ rtl/vpl_front.sv @@
// ----------------------------------------------------------------------------
// vpl_front
// Takes a vertex, runs the matrix one column a cycle and forms the screen
// numerators and divisor, then pushes the work word to the queue.
// ----------------------------------------------------------------------------
module vpl_front import vpl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_vertex i_in_word,
    input  logic    i_full,
    output logic    o_push,
    output t_work   o_work
);

    t_fe_state r_state, n_state;
    t_vertex   r_vtx;
    logic signed [CLIP_W-1:0] r_cx, r_cy, r_cw;
    logic signed [NUM_W-1:0]  r_nx, r_ny;

    logic [1:0]               w_col;
    logic signed [15:0]       w_c0, w_c1, w_c2, w_c3;
    logic signed [31:0]       w_p0, w_p1, w_p2;
    logic signed [CLIP_W-1:0] w_mac;
    logic signed [CLIP_W-1:0] w_csel, w_wsel;
    logic [12:0]              w_size;
    logic [11:0]              w_origin;
    logic [15:0]              w_off;
    logic signed [CLIP_W+13:0] w_prod_c;
    logic signed [CLIP_W+16:0] w_prod_o;
    logic signed [NUM_W-1:0]  w_num;
    logic                     w_wneg;
    logic [CLIP_W-1:0]        w_wmag;
    logic                     w_accept;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FE_IDLE:  if (i_in_valid) n_state = FE_MAT_X;
            FE_MAT_X: n_state = FE_MAT_Y;
            FE_MAT_Y: n_state = FE_MAT_W;
            FE_MAT_W: n_state = FE_NUM_X;
            FE_NUM_X: n_state = FE_NUM_Y;
            FE_NUM_Y: n_state = FE_PUSH;
            FE_PUSH:  if (!i_full) n_state = FE_IDLE;
            default:  n_state = FE_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall = (r_state != FE_IDLE);
        w_accept   = (r_state == FE_IDLE) && i_in_valid;
        o_push     = (r_state == FE_PUSH) && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // one matrix column per cycle
    always_comb begin
        unique case (r_state)
            FE_MAT_X: w_col = 2'd0;
            FE_MAT_Y: w_col = 2'd1;
            default:  w_col = 2'd3;
        endcase
        w_c0  = i_cfg.matrix[0][{w_col, 4'b0} +: 16];
        w_c1  = i_cfg.matrix[1][{w_col, 4'b0} +: 16];
        w_c2  = i_cfg.matrix[2][{w_col, 4'b0} +: 16];
        w_c3  = i_cfg.matrix[3][{w_col, 4'b0} +: 16];
        w_p0  = r_vtx.pos_x * w_c0;
        w_p1  = r_vtx.pos_y * w_c1;
        w_p2  = r_vtx.pos_z * w_c2;
        w_mac = CLIP_W'(w_p0) + CLIP_W'(w_p1) + CLIP_W'(w_p2) + (CLIP_W'(w_c3) <<< 8);
    end

    // numerator: c*size + (2*origin + size)*w with c = x or -y, w replaced by 1.0 when zero
    always_comb begin
        if (r_state == FE_NUM_Y) begin
            w_csel   = -r_cy;
            w_size   = i_cfg.height;
            w_origin = i_cfg.top;
        end else begin
            w_csel   = r_cx;
            w_size   = i_cfg.width;
            w_origin = i_cfg.left;
        end
        w_wsel   = (r_cw != '0) ? r_cw : ONE_Q20;
        w_off    = {3'b0, w_origin, 1'b0} + {3'b0, w_size};
        w_prod_c = w_csel * $signed({1'b0, w_size});
        w_prod_o = w_wsel * $signed({1'b0, w_off});
        w_num    = NUM_W'(w_prod_c) + NUM_W'(w_prod_o);
    end

    // fold the sign of w into the numerator so the divisor is positive
    always_comb begin
        w_wneg       = r_cw[CLIP_W-1];
        w_wmag       = w_wneg ? CLIP_W'(-r_cw) : CLIP_W'(r_cw);
        o_work.num_x = w_wneg ? -r_nx : r_nx;
        o_work.num_y = w_wneg ? -r_ny : r_ny;
        o_work.den   = (r_cw != '0) ? DEN_W'({w_wmag, 1'b0}) : DEN_W_ZERO;
        o_work.last  = r_vtx.last_vertex;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_vtx <= i_in_word;
        if (r_state == FE_MAT_X) r_cx <= w_mac;
        if (r_state == FE_MAT_Y) r_cy <= w_mac;
        if (r_state == FE_MAT_W) r_cw <= w_mac;
        if (r_state == FE_NUM_X) r_nx <= w_num;
        if (r_state == FE_NUM_Y) r_ny <= w_num;
    end

endmodule

@@ rtl/vpl_fifo.sv @@
// ----------------------------------------------------------------------------
// vpl_fifo
// Two-entry queue of work words between the transform and the divide side.
// ----------------------------------------------------------------------------
module vpl_fifo import vpl_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_work        i_data,
    input  logic         i_pop,
    output t_work        o_data,
    output t_fifo_status o_status
);

    t_work      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    always_comb begin
        o_status.full  = (r_count == 2'd2);
        o_status.empty = (r_count == 2'd0);
        o_data         = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

@@ rtl/vpl_back.sv @@
// ----------------------------------------------------------------------------
// vpl_back
// Divides both numerators one quotient bit a cycle, saturates, and pairs
// screen points into segments through an output register.
// ----------------------------------------------------------------------------
module vpl_back import vpl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_work    i_work,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_segment o_out_word
);

    t_be_state r_state, n_state;
    t_work     r_work;
    logic [NUM_W-1:0]  r_rem_x, r_rem_y;
    logic [QBITS-1:0]  r_q_x, r_q_y;
    logic              r_neg_x, r_neg_y, r_sat_x, r_sat_y;
    logic [3:0]        r_cnt;
    logic signed [15:0] r_sx, r_sy, r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic              r_inside;
    logic              r_out_valid;
    t_segment          r_out;

    logic [NUM_W-1:0]  w_mag_x, w_mag_y, w_lim, w_dsh;
    logic [NUM_W:0]    w_tx, w_ty;
    logic signed [15:0] w_sx, w_sy;
    logic              w_out_free, w_emit;
    t_segment          w_seg;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BE_IDLE:   if (!i_empty) n_state = BE_LOAD;
            BE_LOAD:   n_state = BE_DIV;
            BE_DIV:    if (r_cnt == 4'd0) n_state = BE_PAIR;
            BE_PAIR: begin
                if (r_inside)              n_state = BE_EMIT_A;
                else if (r_work.last)      n_state = BE_EMIT_B;
                else                       n_state = BE_IDLE;
            end
            BE_EMIT_A: if (w_out_free) n_state = r_work.last ? BE_EMIT_B : BE_IDLE;
            BE_EMIT_B: if (w_out_free) n_state = BE_IDLE;
            default:   n_state = BE_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == BE_IDLE) && !i_empty;
        w_emit = ((r_state == BE_EMIT_A) || (r_state == BE_EMIT_B)) && w_out_free;
        if (r_state == BE_EMIT_A) begin
            w_seg = '{start_x: r_prev_x, start_y: r_prev_y, end_x: r_sx, end_y: r_sy,
                      closing_segment: 1'b0};
        end else begin
            w_seg = '{start_x: r_sx, start_y: r_sy, end_x: r_first_x, end_y: r_first_y,
                      closing_segment: 1'b1};
        end
    end

    // divider datapath
    always_comb begin
        w_mag_x = r_work.num_x[NUM_W-1] ? NUM_W'(-r_work.num_x) : NUM_W'(r_work.num_x);
        w_mag_y = r_work.num_y[NUM_W-1] ? NUM_W'(-r_work.num_y) : NUM_W'(r_work.num_y);
        w_lim   = NUM_W'(r_work.den) << QBITS;
        w_dsh   = NUM_W'(r_work.den) << r_cnt;
        w_tx    = {1'b0, r_rem_x} - {1'b0, w_dsh};
        w_ty    = {1'b0, r_rem_y} - {1'b0, w_dsh};
        if (r_sat_x)      w_sx = r_neg_x ? 16'sh8000 : 16'sh7fff;
        else if (r_neg_x) w_sx = 16'(-$signed({1'b0, r_q_x}));
        else              w_sx = $signed({1'b0, r_q_x});
        if (r_sat_y)      w_sy = r_neg_y ? 16'sh8000 : 16'sh7fff;
        else if (r_neg_y) w_sy = 16'(-$signed({1'b0, r_q_y}));
        else              w_sy = $signed({1'b0, r_q_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BE_IDLE;
            r_inside    <= 1'b0;
            r_out_valid <= 1'b0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit)            r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (r_state == BE_PAIR && !r_inside) begin
                r_first_x <= w_sx;
                r_first_y <= w_sy;
                r_prev_x  <= w_sx;
                r_prev_y  <= w_sy;
                r_inside  <= !r_work.last;
            end
            if (r_state == BE_EMIT_A && w_out_free) begin
                r_prev_x <= r_sx;
                r_prev_y <= r_sy;
            end
            if (r_state == BE_EMIT_B && w_out_free) r_inside <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_work <= i_work;
        if (r_state == BE_LOAD) begin
            r_rem_x <= w_mag_x;
            r_rem_y <= w_mag_y;
            r_neg_x <= r_work.num_x[NUM_W-1];
            r_neg_y <= r_work.num_y[NUM_W-1];
            r_sat_x <= (w_mag_x >= w_lim);
            r_sat_y <= (w_mag_y >= w_lim);
            r_q_x   <= '0;
            r_q_y   <= '0;
            r_cnt   <= 4'(QBITS - 1);
        end
        if (r_state == BE_DIV) begin
            if (!w_tx[NUM_W]) begin
                r_rem_x        <= w_tx[NUM_W-1:0];
                r_q_x[r_cnt]   <= 1'b1;
            end
            if (!w_ty[NUM_W]) begin
                r_rem_y        <= w_ty[NUM_W-1:0];
                r_q_y[r_cnt]   <= 1'b1;
            end
            r_cnt <= r_cnt - 4'd1;
        end
        if (r_state == BE_PAIR) begin
            r_sx <= w_sx;
            r_sy <= w_sy;
        end
        if (w_emit) r_out <= w_seg;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
